>>> rtl/hetc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hetc_pkg
// Shared widths, codes, configuration type and saturation helper for the
// Hermite eased tween channel.
// ----------------------------------------------------------------------------
package hetc_pkg;

  localparam int OpW    = 2;
  localparam int DtW    = 16;
  localparam int PosW   = 16;
  localparam int ValW   = 16;
  localparam int XyzW   = 48;
  localparam int IdxW   = 3;
  localparam int CfgDW  = 48;

  // serial multiplier geometry
  localparam int MulAW  = 18;
  localparam int MulBW  = 20;
  localparam int MulPW  = 38;
  localparam int DigW   = 4;
  localparam int NumDig = MulBW / DigW;
  localparam int CntW   = $clog2(NumDig);

  localparam int SatW   = 27;
  localparam int SatMin = -32768;
  localparam int SatMax = 32767;
  localparam int OneQ16 = 65536;
  localparam int RndF   = 32768;
  localparam int RndC   = 2048;
  localparam int IncSh  = 8;

  typedef enum logic [OpW-1:0] {
    OpTick    = 2'd0,
    OpRestart = 2'd1,
    OpDisable = 2'd2,
    OpEnable  = 2'd3
  } op_e;

  typedef enum logic [IdxW-1:0] {
    RegTimeScale    = 3'd0,
    RegLoopMode     = 3'd1,
    RegCurveStart   = 3'd2,
    RegCurveEnd     = 3'd3,
    RegTangentStart = 3'd4,
    RegTangentEnd   = 3'd5,
    RegFromXyz      = 3'd6,
    RegToXyz        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [ValW-1:0] time_scale;
    logic            loop_mode;
    logic [ValW-1:0] curve_start;
    logic [ValW-1:0] curve_end;
    logic [ValW-1:0] tangent_start;
    logic [ValW-1:0] tangent_end;
    logic [XyzW-1:0] from_xyz;
    logic [XyzW-1:0] to_xyz;
  } cfg_t;

  function automatic logic [ValW-1:0] sat16(input logic signed [SatW-1:0] v);
    logic [ValW-1:0] r;
    if (v < SatW'(SatMin)) begin
      r = ValW'(SatMin);
    end else if (v > SatW'(SatMax)) begin
      r = ValW'(SatMax);
    end else begin
      r = v[ValW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hetc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hetc_if
// Valid/ready channels of the tween channel: command words in, xyz words out.
// ----------------------------------------------------------------------------
interface hetc_in_if import hetc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [DtW-1:0]   delta_time;

  modport source (output valid, operation, delta_time, input ready);
  modport sink   (input valid, operation, delta_time, output ready);
endinterface

interface hetc_out_if import hetc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] out_x;
  logic signed [ValW-1:0] out_y;
  logic signed [ValW-1:0] out_z;
  logic                   finished;

  modport source (output valid, out_x, out_y, out_z, finished, input ready);
  modport sink   (input valid, out_x, out_y, out_z, finished, output ready);
endinterface
`default_nettype wire

>>> rtl/hetc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hetc_cfg
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module hetc_cfg import hetc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [IdxW-1:0]  idx_i,
  input  wire logic [CfgDW-1:0] data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_scale    <= ValW'(256);
      cfg_q.loop_mode     <= 1'b0;
      cfg_q.curve_start   <= ValW'(0);
      cfg_q.curve_end     <= ValW'(4096);
      cfg_q.tangent_start <= ValW'(2048);
      cfg_q.tangent_end   <= ValW'(410);
      cfg_q.from_xyz      <= XyzW'(0);
      cfg_q.to_xyz        <= XyzW'(0);
    end else if (we_i) begin
      case (reg_idx_e'(idx_i))
        RegTimeScale:    cfg_q.time_scale    <= data_i[ValW-1:0];
        RegLoopMode:     cfg_q.loop_mode     <= data_i[0];
        RegCurveStart:   cfg_q.curve_start   <= data_i[ValW-1:0];
        RegCurveEnd:     cfg_q.curve_end     <= data_i[ValW-1:0];
        RegTangentStart: cfg_q.tangent_start <= data_i[ValW-1:0];
        RegTangentEnd:   cfg_q.tangent_end   <= data_i[ValW-1:0];
        RegFromXyz:      cfg_q.from_xyz      <= data_i[XyzW-1:0];
        RegToXyz:        cfg_q.to_xyz        <= data_i[XyzW-1:0];
        default:         cfg_q.loop_mode     <= cfg_q.loop_mode;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> rtl/hetc_smul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hetc_smul
// Digit-serial signed multiply-accumulate: the multiplier shifts out one
// 4-bit digit per cycle, most significant digit signed.
// ----------------------------------------------------------------------------
module hetc_smul import hetc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    accum_i,
  input  wire logic signed [MulAW-1:0] a_i,
  input  wire logic signed [MulBW-1:0] b_i,
  output logic                         done_o,
  output logic signed [MulPW-1:0]      p_o
);

  logic signed [MulPW-1:0] a_sh_q;
  logic        [MulBW-1:0] b_sh_q;
  logic        [CntW-1:0]  cnt_q;
  logic                    busy_q;
  logic                    done_q;
  logic signed [MulPW-1:0] acc_q;

  logic                    last;
  logic signed [DigW:0]    digit;
  logic signed [MulPW-1:0] partial;

  assign last    = (cnt_q == CntW'(NumDig - 1));
  assign digit   = $signed({last & b_sh_q[DigW-1], b_sh_q[DigW-1:0]});
  assign partial = MulPW'(a_sh_q * digit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_sh_q <= '0;
      b_sh_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_sh_q <= MulPW'(a_i);
        b_sh_q <= b_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
        if (!accum_i) begin
          acc_q <= '0;
        end
      end else if (busy_q) begin
        acc_q  <= acc_q + partial;
        a_sh_q <= a_sh_q <<< DigW;
        b_sh_q <= b_sh_q >> DigW;
        cnt_q  <= cnt_q + CntW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiply started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("multiply done without a busy phase");

endmodule
`default_nettype wire

>>> rtl/hermite_eased_tween_channel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hermite_eased_tween_channel
// One animation channel: Hermite-eased interpolation of an xyz vector.
// ----------------------------------------------------------------------------
// in_i takes command words (tick, restart, disable, enable); out_o gives one
// xyz word for each tick that arrives while the channel runs, with finished
// set on the tick that ends a play-once animation. Configuration registers
// are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must
// write them only while idle, as the block itself does not enforce this.
// Restart, disable, enable and a tick while stopped are handled in the idle
// state and give no word. A running tick goes through ten multiplies on one
// shared digit-serial multiplier (five 4-bit digits); a finishing tick skips
// the three component multiplies.
// The next command word is taken once the current one is done; a finished
// word waits in the output register, and the block only holds if a second
// word is ready while the first has not yet been taken.
// After reset the channel is stopped at position zero with the register
// defaults loaded and no word pending.
// ----------------------------------------------------------------------------
module hermite_eased_tween_channel import hetc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  hetc_in_if.sink               in_i,
  hetc_out_if.source            out_o,
  input  wire logic             cfg_we_i,
  input  wire logic [IdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_T2,
    S_T3,
    S_ACC,
    S_INC,
    S_COMP,
    S_OUT
  } state_e;

  cfg_t cfg;

  state_e          state_q;
  logic [PosW-1:0] pos_q;
  logic            running_q;
  logic [DtW-1:0]  dt_q;
  logic [PosW-1:0] t2_q;
  logic [PosW-1:0] t3_q;
  logic [ValW-1:0] frac_q;
  logic [1:0]      k_q;
  logic            start_q;
  logic            fin_q;
  logic [ValW-1:0] res_q [3];

  logic            out_valid_q;
  logic [ValW-1:0] out_x_q;
  logic [ValW-1:0] out_y_q;
  logic [ValW-1:0] out_z_q;
  logic            out_fin_q;

  logic                    mul_done;
  logic signed [MulPW-1:0] mul_p;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic                    mul_acc;

  logic signed [MulBW-1:0] t_s, t2_s, t3_s;
  logic signed [MulBW-1:0] h00, h01, h10, h11, h_sel;
  logic        [ValW-1:0]  coef_sel;
  logic        [ValW-1:0]  from_c, to_c;
  logic signed [ValW:0]    diff_s;
  logic signed [MulPW-1:0] frac_r;
  logic signed [MulPW-1:0] comp_r;
  logic signed [SatW-1:0]  comp_v;
  logic        [23:0]      inc;
  logic        [24:0]      sum;

  hetc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // hermite basis from the stored powers
  assign t_s  = $signed({4'b0, pos_q});
  assign t2_s = $signed({4'b0, t2_q});
  assign t3_s = $signed({4'b0, t3_q});
  assign h00  = (t3_s <<< 1) - (t2_s + (t2_s <<< 1)) + MulBW'(OneQ16);
  assign h01  = (t2_s + (t2_s <<< 1)) - (t3_s <<< 1);
  assign h10  = t3_s - (t2_s <<< 1) + t_s;
  assign h11  = t3_s - t2_s;

  always_comb begin
    case (k_q)
      2'd0: begin
        h_sel    = h00;
        coef_sel = cfg.curve_start;
        from_c   = cfg.from_xyz[15:0];
        to_c     = cfg.to_xyz[15:0];
      end
      2'd1: begin
        h_sel    = h01;
        coef_sel = cfg.curve_end;
        from_c   = cfg.from_xyz[31:16];
        to_c     = cfg.to_xyz[31:16];
      end
      2'd2: begin
        h_sel    = h10;
        coef_sel = cfg.tangent_start;
        from_c   = cfg.from_xyz[47:32];
        to_c     = cfg.to_xyz[47:32];
      end
      default: begin
        h_sel    = h11;
        coef_sel = cfg.tangent_end;
        from_c   = cfg.from_xyz[15:0];
        to_c     = cfg.to_xyz[15:0];
      end
    endcase
  end

  assign diff_s = $signed({to_c[ValW-1], to_c}) - $signed({from_c[ValW-1], from_c});

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_acc = 1'b0;
    case (state_q)
      S_T2: begin
        mul_a = $signed({2'b0, pos_q});
        mul_b = t_s;
      end
      S_T3: begin
        mul_a = $signed({2'b0, pos_q});
        mul_b = t2_s;
      end
      S_ACC: begin
        mul_a   = MulAW'($signed(coef_sel));
        mul_b   = h_sel;
        mul_acc = (k_q != 2'd0);
      end
      S_INC: begin
        mul_a = $signed({2'b0, cfg.time_scale});
        mul_b = $signed({4'b0, dt_q});
      end
      S_COMP: begin
        mul_a = MulAW'(diff_s);
        mul_b = MulBW'($signed(frac_q));
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  hetc_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .accum_i (mul_acc),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // rounding, nearest with ties upward
  assign frac_r = (mul_p + MulPW'(RndF)) >>> 16;
  assign comp_r = (mul_p + MulPW'(RndC)) >>> 12;
  assign comp_v = SatW'(comp_r) + SatW'($signed(from_c));
  assign inc    = mul_p[IncSh+23:IncSh];
  assign sum    = {9'b0, pos_q} + {1'b0, inc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      running_q   <= 1'b0;
      dt_q        <= '0;
      t2_q        <= '0;
      t3_q        <= '0;
      frac_q      <= '0;
      k_q         <= '0;
      start_q     <= 1'b0;
      fin_q       <= 1'b0;
      res_q       <= '{default: '0};
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_z_q     <= '0;
      out_fin_q   <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            case (op_e'(in_i.operation))
              OpRestart: begin
                pos_q     <= '0;
                running_q <= 1'b1;
              end
              OpDisable: running_q <= 1'b0;
              OpEnable:  running_q <= 1'b1;
              OpTick: begin
                if (running_q) begin
                  dt_q    <= in_i.delta_time;
                  start_q <= 1'b1;
                  state_q <= S_T2;
                end
              end
              default: running_q <= running_q;
            endcase
          end
        end
        S_T2: begin
          if (mul_done) begin
            t2_q    <= mul_p[31:16];
            start_q <= 1'b1;
            state_q <= S_T3;
          end
        end
        S_T3: begin
          if (mul_done) begin
            t3_q    <= mul_p[31:16];
            k_q     <= 2'd0;
            start_q <= 1'b1;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (mul_done) begin
            start_q <= 1'b1;
            if (k_q == 2'd3) begin
              frac_q  <= sat16(SatW'(frac_r));
              state_q <= S_INC;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        S_INC: begin
          if (mul_done) begin
            if (sum[24:16] != 9'd0 && !cfg.loop_mode) begin
              fin_q     <= 1'b1;
              running_q <= 1'b0;
              res_q[0]  <= cfg.to_xyz[15:0];
              res_q[1]  <= cfg.to_xyz[31:16];
              res_q[2]  <= cfg.to_xyz[47:32];
              state_q   <= S_OUT;
            end else begin
              pos_q   <= sum[15:0];
              fin_q   <= 1'b0;
              k_q     <= 2'd0;
              start_q <= 1'b1;
              state_q <= S_COMP;
            end
          end
        end
        S_COMP: begin
          if (mul_done) begin
            res_q[k_q] <= sat16(comp_v);
            if (k_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              k_q     <= k_q + 2'd1;
              start_q <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_q[0];
            out_y_q     <= res_q[1];
            out_z_q     <= res_q[2];
            out_fin_q   <= fin_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.out_x    = $signed(out_x_q);
  assign out_o.out_y    = $signed(out_y_q);
  assign out_o.out_z    = $signed(out_z_q);
  assign out_o.finished = out_fin_q;

  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q != S_IDLE)
    else $error("multiply result with no tick in progress");

  a_word_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("output word loaded outside the output state");

  a_finish_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && out_fin_q |-> !running_q)
    else $error("finished word while channel still running");

endmodule
`default_nettype wire
